/* hdl/lhc_pkg.sv */
// Package for the handle cache: sizes, status codes and the structs
// that travel along the row of cache cells. No dependencies.
package lhc_pkg;

   localparam int MAX_ENTRIES   = 16;
   localparam int KEY_BITS      = 64;
   localparam int STAMP_BITS    = 32;
   localparam int SLOT_BITS     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int SIZE_BITS     = $clog2(MAX_ENTRIES + 1);
   localparam int CFG_BITS      = 5;
   localparam int STATUS_BITS   = 3;
   localparam int RSP_SLOT_BITS = 4;
   localparam int CFG_RESET     = 10;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_HIT      = 3'd0,
      ST_FILLED   = 3'd1,
      ST_REPLACED = 3'd2,
      ST_FAILED   = 3'd3,
      ST_FLUSHED  = 3'd4
   } status_type;

   // Running search result handed from one cell to the next
   typedef struct packed {
      logic                  go;
      logic                  hit;
      logic [SLOT_BITS-1:0]  hit_slot;
      logic                  have_free;
      logic [SLOT_BITS-1:0]  free_slot;
      logic                  have_old;
      logic [STAMP_BITS-1:0] old_stamp;
      logic [SLOT_BITS-1:0]  old_slot;
   } scan_type;

   // Entry update broadcast to every cell
   typedef struct packed {
      logic                  flush;
      logic                  en;
      logic [SLOT_BITS-1:0]  slot;
      logic                  valid;
      logic                  load_key;
      logic                  load_stamp;
      logic [KEY_BITS-1:0]   key;
      logic [STAMP_BITS-1:0] stamp;
   } write_type;

endpackage

/* hdl/lhc_if.sv */
// Handshake channels of the handle cache: request and response.
// Depends on lhc_pkg for field widths.
interface lhc_req_if;
   logic                         valid;
   logic                         ready;
   logic                         action;
   logic [lhc_pkg::KEY_BITS-1:0] name_key;
   logic                         open_ok;

   modport source (output valid, output action, output name_key, output open_ok,
                   input ready);
   modport sink   (input valid, input action, input name_key, input open_ok,
                   output ready);
endinterface

interface lhc_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [lhc_pkg::STATUS_BITS-1:0]   status;
   logic [lhc_pkg::RSP_SLOT_BITS-1:0] slot;
   logic                              slot_valid;

   modport source (output valid, output status, output slot, output slot_valid,
                   input ready);
   modport sink   (input valid, input status, input slot, input slot_valid,
                   output ready);
endinterface

/* hdl/lhc_cell.sv */
// One cache slot: valid bit, key and use stamp, plus one stage of the
// search wave that moves along the row. Depends on lhc_pkg.
module lhc_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [lhc_pkg::SLOT_BITS-1:0] cell_index,
   input  logic [lhc_pkg::SIZE_BITS-1:0] slots_in_use,
   input  logic [lhc_pkg::KEY_BITS-1:0]  lookup_key,
   input  lhc_pkg::write_type            wr,
   input  lhc_pkg::scan_type             scan_prev,
   output lhc_pkg::scan_type             scan_next
);
   import lhc_pkg::*;

   logic                  valid_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [STAMP_BITS-1:0] stamp_ff;
   scan_type              scan_ff;
   scan_type              scan_in;
   logic                  in_use;
   logic                  sel;

   assign in_use = SIZE_BITS'(cell_index) < slots_in_use;
   assign sel    = wr.en && (wr.slot == cell_index);

   // Fold this slot into the running search
   always_comb begin
      scan_in = scan_prev;
      if (scan_prev.go && !scan_prev.hit && in_use) begin
         if (!valid_ff) begin
            if (!scan_prev.have_free) begin
               scan_in.have_free = 1'b1;
               scan_in.free_slot = cell_index;
            end
         end else if (key_ff == lookup_key) begin
            scan_in.hit      = 1'b1;
            scan_in.hit_slot = cell_index;
         end else if (!scan_prev.have_old || stamp_ff < scan_prev.old_stamp) begin
            scan_in.have_old  = 1'b1;
            scan_in.old_stamp = stamp_ff;
            scan_in.old_slot  = cell_index;
         end
      end
   end

   // Advance the search wave by one cell
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff.go <= 1'b0;
      end else begin
         scan_ff.go <= scan_in.go;
      end
      scan_ff.hit       <= scan_in.hit;
      scan_ff.hit_slot  <= scan_in.hit_slot;
      scan_ff.have_free <= scan_in.have_free;
      scan_ff.free_slot <= scan_in.free_slot;
      scan_ff.have_old  <= scan_in.have_old;
      scan_ff.old_stamp <= scan_in.old_stamp;
      scan_ff.old_slot  <= scan_in.old_slot;
   end

   assign scan_next = scan_ff;

   // Update the slot contents
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (wr.flush) begin
         valid_ff <= 1'b0;
      end else if (sel) begin
         valid_ff <= wr.valid;
      end
      if (sel && wr.load_key) begin
         key_ff <= wr.key;
      end
      if (sel && wr.load_stamp) begin
         stamp_ff <= wr.stamp;
      end
   end

endmodule

/* hdl/lru_handle_cache.sv */
// Handle cache with LRU replacement: one lookup or flush per transaction.
// A lookup passes through launch, a search wave that crosses the cell row one
// cell per cycle, and finish; a flush goes from accept straight to finish.
// Throughput: one transaction at a time; no new request is taken until the last one has finished.
// Reset: synchronous; all slots empty, size register at 10, counters at zero.
module lru_handle_cache (
   input  logic                         clock,
   input  logic                         reset,
   lhc_req_if.sink                      req_chan,
   lhc_rsp_if.source                    rsp_chan,
   input  logic                         csr_write_enable,
   input  logic [lhc_pkg::CFG_BITS-1:0] csr_write_data
);
   import lhc_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_LAUNCH = 4'b0010,
      S_SCAN   = 4'b0100,
      S_FINISH = 4'b1000
   } state_type;

   state_type                 state_ff, state_in;
   logic [SIZE_BITS-1:0]      size_ff;
   logic [SIZE_BITS-1:0]      slots_ff, slots_in;
   logic [STAMP_BITS-1:0]     ctr_ff, ctr_in;
   logic                      action_ff;
   logic                      ok_ff;
   logic [KEY_BITS-1:0]       key_ff;
   scan_type                  acc_ff;
   scan_type                  chain [MAX_ENTRIES+1];
   logic [MAX_ENTRIES-1:0]    go_vec;
   write_type                 wr;
   logic                      req_fire;
   logic                      finish_fire;
   logic                      rsp_valid_ff, rsp_valid_in;
   status_type                rsp_status_ff, rsp_status_in;
   logic [RSP_SLOT_BITS-1:0]  rsp_slot_ff, rsp_slot_in;
   logic                      rsp_slot_valid_ff, rsp_slot_valid_in;
   logic [SLOT_BITS-1:0]      target;
   logic                      evict;
   logic                      grow;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign finish_fire    = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_chan.ready);

   // Seed the search wave at the head of the row
   always_comb begin
      chain[0]    = '0;
      chain[0].go = (state_ff == S_LAUNCH);
   end

   // Row of slot cells
   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      lhc_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .cell_index   (SLOT_BITS'(i)),
         .slots_in_use (slots_ff),
         .lookup_key   (key_ff),
         .wr           (wr),
         .scan_prev    (chain[i]),
         .scan_next    (chain[i+1])
      );
      assign go_vec[i] = chain[i+1].go;
   end

   // Sequence one transaction through launch, scan and finish
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = req_chan.action ? S_FINISH : S_LAUNCH;
            end
         end
         S_LAUNCH: state_in = S_SCAN;
         S_SCAN: begin
            if (chain[MAX_ENTRIES].go) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (finish_fire) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Decide flush, hit, fill, grow or evict, and build the slot update
   always_comb begin
      wr                = '0;
      wr.key            = key_ff;
      wr.stamp          = ctr_ff;
      slots_in          = slots_ff;
      ctr_in            = ctr_ff;
      rsp_status_in     = ST_FLUSHED;
      rsp_slot_in       = '0;
      rsp_slot_valid_in = 1'b0;
      evict             = 1'b0;
      grow              = 1'b0;
      target            = acc_ff.old_slot;
      if (acc_ff.have_free) begin
         target = acc_ff.free_slot;
      end else if (slots_ff < size_ff && 32'(slots_ff) < 32'(MAX_ENTRIES)) begin
         target = slots_ff[SLOT_BITS-1:0];
         grow   = 1'b1;
      end else begin
         evict  = 1'b1;
      end
      if (finish_fire) begin
         if (action_ff) begin
            wr.flush = 1'b1;
         end else if (acc_ff.hit) begin
            wr.en             = 1'b1;
            wr.slot           = acc_ff.hit_slot;
            wr.valid          = 1'b1;
            wr.load_stamp     = 1'b1;
            ctr_in            = ctr_ff + 1'b1;
            rsp_status_in     = ST_HIT;
            rsp_slot_in       = RSP_SLOT_BITS'(acc_ff.hit_slot);
            rsp_slot_valid_in = 1'b1;
         end else begin
            if (grow) begin
               slots_in = slots_ff + 1'b1;
            end
            if (!ok_ff) begin
               // drop the chosen slot; an evicted entry stays empty
               wr.en         = evict;
               wr.slot       = target;
               wr.valid      = 1'b0;
               rsp_status_in = ST_FAILED;
            end else begin
               wr.en             = 1'b1;
               wr.slot           = target;
               wr.valid          = 1'b1;
               wr.load_key       = 1'b1;
               wr.load_stamp     = 1'b1;
               ctr_in            = ctr_ff + 1'b1;
               rsp_status_in     = evict ? ST_REPLACED : ST_FILLED;
               rsp_slot_in       = RSP_SLOT_BITS'(target);
               rsp_slot_valid_in = 1'b1;
            end
         end
      end
   end

   // Hold the response until the sink takes it
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         slots_ff     <= '0;
         ctr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         size_ff      <= SIZE_BITS'(CFG_RESET);
      end else begin
         state_ff     <= state_in;
         slots_ff     <= slots_in;
         ctr_ff       <= ctr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            if (csr_write_data == '0) begin
               size_ff <= SIZE_BITS'(1);
            end else if (32'(csr_write_data) > 32'(MAX_ENTRIES)) begin
               size_ff <= SIZE_BITS'(MAX_ENTRIES);
            end else begin
               size_ff <= SIZE_BITS'(csr_write_data);
            end
         end
      end
   end

   // Capture the request and the finished search
   always_ff @(posedge clock) begin
      if (req_fire) begin
         action_ff <= req_chan.action;
         ok_ff     <= req_chan.open_ok;
         key_ff    <= req_chan.name_key;
      end
      if (state_ff == S_SCAN && chain[MAX_ENTRIES].go) begin
         acc_ff <= chain[MAX_ENTRIES];
      end
      if (finish_fire) begin
         rsp_status_ff     <= rsp_status_in;
         rsp_slot_ff       <= rsp_slot_in;
         rsp_slot_valid_ff <= rsp_slot_valid_in;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.slot       = rsp_slot_ff;
   assign rsp_chan.slot_valid = rsp_slot_valid_ff;

`ifndef SYNTH
   a_one_wave: assert property (@(posedge clock) disable iff (reset)
      $onehot0(go_vec))
      else $error("more than one search wave in the cell row");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> go_vec == '0)
      else $error("search wave active while idle");

   a_slots_bound: assert property (@(posedge clock) disable iff (reset)
      32'(slots_ff) <= 32'(MAX_ENTRIES))
      else $error("slots in use beyond capacity");

   a_size_range: assert property (@(posedge clock) disable iff (reset)
      size_ff != '0 && 32'(size_ff) <= 32'(MAX_ENTRIES))
      else $error("size register out of range");

   a_ctr_step: assert property (@(posedge clock) disable iff (reset)
      finish_fire && rsp_slot_valid_in |=> ctr_ff == $past(ctr_ff) + 1'b1)
      else $error("use counter did not advance on a stamp write");
`endif

endmodule

/* dv/tb.sv */
// Testbench for lru_handle_cache: drives lookups and flushes through the request
// channel, predicts every response with a local cache model and checks it.
// Depends on lhc_pkg and the lhc_req_if / lhc_rsp_if channel interfaces.
module tb;
   import lhc_pkg::*;

   localparam int KEY_POOL  = 24;
   localparam int LATENCY   = MAX_ENTRIES + 3;
   localparam int ERR_SHOWN = 10;

   typedef struct packed {
      logic                action;
      logic [KEY_BITS-1:0] name_key;
      logic                open_ok;
   } lookup_item_type;

   typedef struct packed {
      status_type               status;
      logic [RSP_SLOT_BITS-1:0] slot;
      logic                     slot_valid;
   } lookup_result_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_write_enable;
   logic [CFG_BITS-1:0] csr_write_data;

   lhc_req_if req_bus ();
   lhc_rsp_if rsp_bus ();

   lru_handle_cache DUT (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_bus),
      .rsp_chan         (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // Stimulus waiting to be offered and responses still owed by the cache
   lookup_item_type   req_backlog [$];
   lookup_result_type owed_rsp [$];

   // Local copy of the cache contents and configuration
   logic                  line_valid [MAX_ENTRIES];
   logic [KEY_BITS-1:0]   line_key   [MAX_ENTRIES];
   logic [STAMP_BITS-1:0] line_stamp [MAX_ENTRIES];
   int                    cur_slot;
   logic                  cur_valid;
   int                    lines_used;
   logic [STAMP_BITS-1:0] use_tick;
   int                    size_limit;

   // Run statistics
   int n_hit, n_fill, n_replace, n_fail, n_flush, size_writes;
   int sent_count;
   int rsp_count;
   int mismatches;

   // Hold-off state of the response side
   int   hold_left;
   logic hold_used;

   logic [KEY_BITS-1:0] key_pool [KEY_POOL];
   logic [KEY_BITS-1:0] last_key;

   // No idling on either side during a window of responses
   wire steady = (rsp_count >= 800) && (rsp_count < 1000);

   always #10 clock = ~clock;

   function automatic void touch_line(int s);
      line_stamp[s] = use_tick;
      use_tick      = use_tick + 1'b1;
   endfunction

   // Advance the cache model by one transaction and return its response
   function automatic lookup_result_type cache_lookup(lookup_item_type it);
      lookup_result_type res;
      int             free_idx, old_idx, target;
      bit             have_free, have_old, evicted;
      logic [STAMP_BITS-1:0] old_stamp;
      res       = '{ST_FLUSHED, '0, 1'b0};
      free_idx  = 0;
      old_idx   = 0;
      have_free = 0;
      have_old  = 0;
      evicted   = 0;
      old_stamp = '0;

      if (it.action) begin
         foreach (line_valid[i]) line_valid[i] = 1'b0;
         cur_valid = 1'b0;
         n_flush++;
         return res;
      end

      // Check the current slot first
      if (cur_valid && line_valid[cur_slot] && line_key[cur_slot] == it.name_key) begin
         touch_line(cur_slot);
         n_hit++;
         return '{ST_HIT, RSP_SLOT_BITS'(cur_slot), 1'b1};
      end

      // Scan slots in use for a match, the first hole and the oldest entry
      cur_valid = 1'b0;
      for (int i = 0; i < lines_used && i < MAX_ENTRIES; i++) begin
         if (!line_valid[i]) begin
            if (!have_free) begin
               have_free = 1;
               free_idx  = i;
            end
         end else begin
            if (line_key[i] == it.name_key) begin
               touch_line(i);
               cur_slot  = i;
               cur_valid = 1'b1;
               n_hit++;
               return '{ST_HIT, RSP_SLOT_BITS'(i), 1'b1};
            end
            if (!have_old || line_stamp[i] < old_stamp) begin
               have_old  = 1;
               old_stamp = line_stamp[i];
               old_idx   = i;
            end
         end
      end

      target = free_idx;
      if (!have_free && lines_used < size_limit && lines_used < MAX_ENTRIES) begin
         target    = lines_used;
         lines_used++;
         have_free = 1;
      end
      if (!have_free) begin
         target             = old_idx;
         line_valid[target] = 1'b0;
         evicted            = 1;
      end

      if (!it.open_ok) begin
         n_fail++;
         return '{ST_FAILED, '0, 1'b0};
      end

      line_valid[target] = 1'b1;
      line_key[target]   = it.name_key;
      touch_line(target);
      cur_slot  = target;
      cur_valid = 1'b1;
      if (evicted) begin
         n_replace++;
         res = '{ST_REPLACED, RSP_SLOT_BITS'(target), 1'b1};
      end else begin
         n_fill++;
         res = '{ST_FILLED, RSP_SLOT_BITS'(target), 1'b1};
      end
      return res;
   endfunction

   // Request driver: offer the next pending transaction, predict on accept
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            owed_rsp.push_back(cache_lookup('{req_bus.action, req_bus.name_key,
                                              req_bus.open_ok}));
            sent_count++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (req_backlog.size() != 0 && (steady || $urandom_range(99) >= 14)) begin
               lookup_item_type nxt;
               nxt = req_backlog.pop_front();
               req_bus.action   <= nxt.action;
               req_bus.name_key <= nxt.name_key;
               req_bus.open_ok  <= nxt.open_ok;
               req_bus.valid    <= 1'b1;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Response ready: random stalls plus one long hold-off to back up the input
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= 0;
         hold_used     <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= hold_left - 1;
      end else if (!hold_used && rsp_count >= 500) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= 400;
         hold_used     <= 1'b1;
      end else begin
         rsp_bus.ready <= steady || ($urandom_range(99) >= 14);
      end
   end

   // Response monitor: compare each accepted response with the oldest one owed
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         rsp_count <= rsp_count + 1;
         if (owed_rsp.size() == 0) begin
            if (mismatches < ERR_SHOWN)
               $display("[%0t] unexpected response: status %0d slot %0d slot_valid %0b",
                        $realtime, rsp_bus.status, rsp_bus.slot, rsp_bus.slot_valid);
            mismatches++;
         end else begin
            lookup_result_type want;
            want = owed_rsp.pop_front();
            if (rsp_bus.status !== want.status || rsp_bus.slot !== want.slot ||
                rsp_bus.slot_valid !== want.slot_valid) begin
               if (mismatches < ERR_SHOWN)
                  $display({"[%0t] response %0d mismatch: expected status %0d slot %0d ",
                            "slot_valid %0b, got status %0d slot %0d slot_valid %0b"},
                           $realtime, rsp_count, want.status, want.slot, want.slot_valid,
                           rsp_bus.status, rsp_bus.slot, rsp_bus.slot_valid);
               mismatches++;
            end
         end
      end
   end

   task automatic add_item(logic action, logic [KEY_BITS-1:0] name_key, logic open_ok);
      req_backlog.push_back('{action, name_key, open_ok});
   endtask

   // Wait until every queued transaction is accepted and answered
   task automatic drain();
      while (req_backlog.size() != 0 || req_bus.valid || owed_rsp.size() != 0)
         @(negedge clock);
   endtask

   // Write the size register while the cache is idle
   task automatic write_size(logic [CFG_BITS-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (int'(value) == 0)
         size_limit = 1;
      else if (int'(value) > MAX_ENTRIES)
         size_limit = MAX_ENTRIES;
      else
         size_limit = int'(value);
      size_writes++;
   endtask

   // Mostly reuse a small key set so hits, fills and evictions all occur
   task automatic add_random_items(int count);
      int roll, span;
      logic [KEY_BITS-1:0] k;
      for (int i = 0; i < count; i++) begin
         roll = $urandom_range(99);
         if (roll < 3) begin
            add_item(1'b1, {$urandom, $urandom}, 1'($urandom_range(1)));
         end else begin
            span = (size_limit + 4 < KEY_POOL) ? size_limit + 4 : KEY_POOL;
            roll = $urandom_range(99);
            if (roll < 10)
               k = {$urandom, $urandom};
            else if (roll < 40)
               k = last_key;
            else
               k = key_pool[$urandom_range(span - 1)];
            last_key = k;
            add_item(1'b0, k, $urandom_range(99) >= 12);
         end
      end
   endtask

   initial begin
      logic [CFG_BITS-1:0] sizes [$];
      logic [KEY_BITS-1:0] ones;

      ones = '1;
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      req_bus.valid    = 1'b0;
      req_bus.action   = 1'b0;
      req_bus.name_key = '0;
      req_bus.open_ok  = 1'b0;
      rsp_bus.ready    = 1'b0;
      rsp_count        = 0;
      sent_count       = 0;
      mismatches       = 0;
      foreach (line_valid[i]) begin
         line_valid[i] = 1'b0;
         line_key[i]   = '0;
         line_stamp[i] = '0;
      end
      cur_slot   = 0;
      cur_valid  = 1'b0;
      lines_used = 0;
      use_tick   = '0;
      size_limit = CFG_RESET;
      foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
      last_key = key_pool[0];

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: extreme keys, current-slot and scan hits, flush,
      // failed open on a free slot and on eviction, LRU replacement
      @(negedge clock);
      add_item(1'b0, '0, 1'b1);
      add_item(1'b0, '0, 1'b0);
      add_item(1'b0, ones, 1'b1);
      add_item(1'b0, '0, 1'b1);
      add_item(1'b1, ones, 1'b1);
      add_item(1'b0, key_pool[0], 1'b0);
      add_item(1'b0, key_pool[0], 1'b1);
      add_item(1'b0, ones, 1'b1);
      for (int i = 1; i <= 8; i++)
         add_item(1'b0, key_pool[i], 1'b1);
      add_item(1'b0, key_pool[9], 1'b1);
      add_item(1'b0, key_pool[10], 1'b0);
      add_item(1'b0, ones, 1'b1);
      add_item(1'b0, key_pool[0], 1'b1);
      add_item(1'b1, '0, 1'b0);
      add_item(1'b0, key_pool[1], 1'b1);
      drain();

      // Random phases over several sizes, extremes and a shrink among them
      sizes = '{5'd0, 5'd31, 5'd3, 5'd16, 5'd1, 5'd17};
      repeat (6) sizes.push_back(CFG_BITS'($urandom_range(31)));
      foreach (sizes[p]) begin
         write_size(sizes[p]);
         @(negedge clock);
         add_random_items(125);
         drain();
      end

      // Let any stray response show up before the verdict
      repeat (2 * LATENCY) @(posedge clock);
      $display("Covered %0d transactions over %0d size settings: %0d hits, %0d fills,",
               sent_count, size_writes + 1, n_hit, n_fill);
      $display("  %0d LRU replacements, %0d failed opens, %0d flushes; %0d mismatches",
               n_replace, n_fail, n_flush, mismatches);
      if (mismatches == 0 && owed_rsp.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // Watchdog
   initial begin
      #8_000_000;
      $display("Run timed out with %0d responses still owed", owed_rsp.size());
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

/* sim.f */
hdl/lhc_pkg.sv
hdl/lhc_if.sv
hdl/lhc_cell.sv
hdl/lru_handle_cache.sv
dv/tb.sv
